[rtl/clr_pkg.sv]
// Shared types and constants for the clipped line rasterizer.
// Used by clr_ctrl, clr_datapath and the top level; depends on nothing.
package clr_pkg;

	localparam int PIX_W      = 14;
	localparam int VIEW_BITS  = 12;
	localparam int COLOR_W    = 8;
	localparam int CFG_ADDR_W = 2;

	typedef enum logic [CFG_ADDR_W-1:0] {
		REG_VIEW_X = 2'd0,
		REG_VIEW_Y = 2'd1,
		REG_VIEW_W = 2'd2,
		REG_VIEW_H = 2'd3
	} cfg_reg_t;

	localparam logic [VIEW_BITS-1:0] VIEW_W_RST = 12'd320;
	localparam logic [VIEW_BITS-1:0] VIEW_H_RST = 12'd240;

	// controller -> datapath
	typedef struct packed {
		logic load;
		logic setup_a;
		logic setup_b;
		logic emit_pix;
		logic emit_reject;
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic too_long;
		logic last_point;
		logic out_free;
	} dp_stat_t;

endpackage

[rtl/clipped_line_rasterizer.sv]
// Channel   Direction  Handshake          Beat
// in        input      in_valid/in_stall  one line command (endpoints, color)
// out       output     out_valid/out_stall one pixel, or one too_long reject
// cfg       input      cfg_we             one viewport register write
//
// After accept a line passes through capture, setup A and setup B; then the
// Bresenham stepper emits one pixel a cycle, or a rejected line gives a single
// too_long beat. Stalls on out hold the stepper.
// in_stall is high from accept until the last beat of the line is registered.
// Reset is asynchronous; viewport resets to origin, 320 x 240.
//
// Top level: clr_ctrl sequencer and clr_datapath. Depends on clr_pkg.
module clipped_line_rasterizer import clr_pkg::*; #(
	parameter int COORD_BITS = 12,
	parameter int MAX_SPAN   = 63
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [CFG_ADDR_W-1:0]        cfg_addr,
	input  logic [VIEW_BITS-1:0]         cfg_wdata,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic signed [COORD_BITS-1:0] start_x,
	input  logic signed [COORD_BITS-1:0] start_y,
	input  logic signed [COORD_BITS-1:0] end_x,
	input  logic signed [COORD_BITS-1:0] end_y,
	input  logic [COLOR_W-1:0]           red,
	input  logic [COLOR_W-1:0]           green,
	input  logic [COLOR_W-1:0]           blue,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic signed [PIX_W-1:0]      pix_x,
	output logic signed [PIX_W-1:0]      pix_y,
	output logic                         visible,
	output logic [COLOR_W-1:0]           pix_red,
	output logic [COLOR_W-1:0]           pix_green,
	output logic [COLOR_W-1:0]           pix_blue,
	output logic                         too_long,
	output logic                         last
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	clr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	clr_datapath #(
		.COORD_BITS (COORD_BITS),
		.MAX_SPAN   (MAX_SPAN)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.start_x   (start_x),
		.start_y   (start_y),
		.end_x     (end_x),
		.end_y     (end_y),
		.red       (red),
		.green     (green),
		.blue      (blue),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.pix_x     (pix_x),
		.pix_y     (pix_y),
		.visible   (visible),
		.pix_red   (pix_red),
		.pix_green (pix_green),
		.pix_blue  (pix_blue),
		.too_long  (too_long),
		.last      (last),
		.cmd       (cmd),
		.stat      (stat)
	);

	// one command in flight at a time
	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("command accepted while another is in flight");

	// reject beat is a single, invisible, final beat
	a_reject_beat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && too_long |-> last && !visible)
		else $error("too_long beat without last or with visible set");

	// pixels of a line come back to back while the sink takes them
	a_no_gap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last |=> out_valid)
		else $error("gap inside a line's pixel run");

	// a command is only taken while the output side is not mid-line
	a_idle_out: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && out_valid |-> last)
		else $error("command accepted while a line still emits");

endmodule

[rtl/clr_ctrl.sv]
// Sequencer for the line rasterizer: command intake, setup A and setup B, pixel run or reject beat.
// Depends on clr_pkg.
module clr_ctrl import clr_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_SETUP_A,
		S_SETUP_B,
		S_EMIT
	} state_t;

	state_t state_q;
	logic   in_stall_q;

	assign in_stall = in_stall_q;

	always_comb begin
		cmd = '0;
		case (state_q)
			S_IDLE:    cmd.load    = in_valid && !in_stall_q;
			S_SETUP_A: cmd.setup_a = 1'b1;
			S_SETUP_B: cmd.setup_b = 1'b1;
			S_EMIT: begin
				if (stat.out_free) begin
					cmd.emit_reject = stat.too_long;
					cmd.emit_pix    = !stat.too_long;
				end
			end
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			in_stall_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (cmd.load) begin
						state_q    <= S_SETUP_A;
						in_stall_q <= 1'b1;
					end
				end
				S_SETUP_A: state_q <= S_SETUP_B;
				S_SETUP_B: state_q <= S_EMIT;
				S_EMIT: begin
					if (stat.out_free && (stat.too_long || stat.last_point)) begin
						state_q    <= S_IDLE;
						in_stall_q <= 1'b0;
					end
				end
				default: begin
					state_q    <= S_IDLE;
					in_stall_q <= 1'b0;
				end
			endcase
		end
	end

endmodule

[rtl/clr_datapath.sv]
// Datapath of the line rasterizer: viewport registers, endpoint setup,
// Bresenham stepper and the output register. Depends on clr_pkg.
module clr_datapath import clr_pkg::*; #(
	parameter int COORD_BITS = 12,
	parameter int MAX_SPAN   = 63
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [CFG_ADDR_W-1:0]        cfg_addr,
	input  logic [VIEW_BITS-1:0]         cfg_wdata,
	input  logic signed [COORD_BITS-1:0] start_x,
	input  logic signed [COORD_BITS-1:0] start_y,
	input  logic signed [COORD_BITS-1:0] end_x,
	input  logic signed [COORD_BITS-1:0] end_y,
	input  logic [COLOR_W-1:0]           red,
	input  logic [COLOR_W-1:0]           green,
	input  logic [COLOR_W-1:0]           blue,
	input  logic                         out_stall,
	output logic                         out_valid,
	output logic signed [PIX_W-1:0]      pix_x,
	output logic signed [PIX_W-1:0]      pix_y,
	output logic                         visible,
	output logic [COLOR_W-1:0]           pix_red,
	output logic [COLOR_W-1:0]           pix_green,
	output logic [COLOR_W-1:0]           pix_blue,
	output logic                         too_long,
	output logic                         last,
	input  dp_cmd_t                      cmd,
	output dp_stat_t                     stat
);

	localparam int CB    = COORD_BITS;
	localparam int CNT_W = $clog2(MAX_SPAN + 2);
	localparam int ERR_W = CNT_W + 2;
	localparam int SUM_W = ((CB > VIEW_BITS) ? CB : VIEW_BITS) + 2;
	localparam logic [CB-1:0] SPAN_LIM = CB'(MAX_SPAN);

	// viewport registers
	logic [VIEW_BITS-1:0] view_x_q, view_y_q, view_w_q, view_h_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			view_x_q <= '0;
			view_y_q <= '0;
			view_w_q <= VIEW_W_RST;
			view_h_q <= VIEW_H_RST;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_addr))
				REG_VIEW_X: view_x_q <= cfg_wdata;
				REG_VIEW_Y: view_y_q <= cfg_wdata;
				REG_VIEW_W: view_w_q <= cfg_wdata;
				REG_VIEW_H: view_h_q <= cfg_wdata;
				default:    view_x_q <= view_x_q;
			endcase
		end
	end

	// command capture
	logic signed [CB-1:0] ax_q, ay_q, bx_q, by_q;
	logic [COLOR_W-1:0]   red_q, green_q, blue_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			ax_q    <= start_x;
			ay_q    <= start_y;
			bx_q    <= end_x;
			by_q    <= end_y;
			red_q   <= red;
			green_q <= green;
			blue_q  <= blue;
		end
	end

	// setup A: deltas, magnitudes, major axis
	logic signed [CB:0] dx_ab, dx_ba, dy_ab, dy_ba;
	logic [CB-1:0]      adx, ady;

	assign dx_ab = (CB+1)'(ax_q) - (CB+1)'(bx_q);
	assign dx_ba = (CB+1)'(bx_q) - (CB+1)'(ax_q);
	assign dy_ab = (CB+1)'(ay_q) - (CB+1)'(by_q);
	assign dy_ba = (CB+1)'(by_q) - (CB+1)'(ay_q);
	assign adx   = dx_ba[CB] ? dx_ab[CB-1:0] : dx_ba[CB-1:0];
	assign ady   = dy_ba[CB] ? dy_ab[CB-1:0] : dy_ba[CB-1:0];

	logic          dx_neg_s1, dx_pos_s1, dy_neg_s1, dy_pos_s1, vert_s1;
	logic [CB-1:0] adx_s1, ady_s1;

	always_ff @(posedge clk) begin
		if (cmd.setup_a) begin
			dx_neg_s1 <= dx_ba[CB];
			dx_pos_s1 <= dx_ab[CB];
			dy_neg_s1 <= dy_ba[CB];
			dy_pos_s1 <= dy_ab[CB];
			adx_s1    <= adx;
			ady_s1    <= ady;
			vert_s1   <= adx < ady;
		end
	end

	// setup B: order endpoints by major coordinate, initial decision term
	logic                 maj_neg, step_up;
	logic signed [CB-1:0] maj0, min0;
	logic [CB-1:0]        span, mdel;
	logic [CNT_W-1:0]     span_c, mdel_c;
	logic [ERR_W-1:0]     inc_b_w, inc_a_w, err_init_w;

	assign maj_neg = vert_s1 ? dy_neg_s1 : dx_neg_s1;
	assign maj0    = vert_s1 ? (maj_neg ? by_q : ay_q) : (maj_neg ? bx_q : ax_q);
	assign min0    = vert_s1 ? (maj_neg ? bx_q : ax_q) : (maj_neg ? by_q : ay_q);
	// minor direction after the swap
	assign step_up = vert_s1 ? (maj_neg ? dx_neg_s1 : dx_pos_s1)
	                         : (maj_neg ? dy_neg_s1 : dy_pos_s1);
	assign span    = vert_s1 ? ady_s1 : adx_s1;
	assign mdel    = vert_s1 ? adx_s1 : ady_s1;
	assign span_c  = span[CNT_W-1:0];
	assign mdel_c  = mdel[CNT_W-1:0];
	assign inc_b_w    = {1'b0, mdel_c, 1'b0};
	assign inc_a_w    = inc_b_w - {1'b0, span_c, 1'b0};
	assign err_init_w = inc_b_w - {2'b00, span_c};

	logic                    too_long_q, step_up_q;
	logic signed [CB-1:0]    cur_major_q, cur_minor_q;
	logic signed [ERR_W-1:0] err_q, inc_a_q, inc_b_q;
	logic [CNT_W-1:0]        points_left_q;

	always_ff @(posedge clk) begin
		if (cmd.setup_b) begin
			too_long_q    <= span > SPAN_LIM;
			step_up_q     <= step_up;
			cur_major_q   <= maj0;
			cur_minor_q   <= min0;
			err_q         <= $signed(err_init_w);
			inc_a_q       <= $signed(inc_a_w);
			inc_b_q       <= $signed(inc_b_w);
			points_left_q <= span_c + CNT_W'(1);
		end else if (cmd.emit_pix) begin
			points_left_q <= points_left_q - CNT_W'(1);
			if (points_left_q != CNT_W'(1)) begin
				cur_major_q <= cur_major_q + CB'(1);
				if (!err_q[ERR_W-1]) begin
					cur_minor_q <= cur_minor_q + (step_up_q ? CB'(1) : {CB{1'b1}});
					err_q       <= err_q + inc_a_q;
				end else begin
					err_q <= err_q + inc_b_q;
				end
			end
		end
	end

	// screen position and clip test of the current point
	logic signed [CB-1:0]    rx, ry;
	logic signed [SUM_W-1:0] rx_e, ry_e, vx_e, vy_e, vw_e, vh_e, sx, sy;
	logic                    vis;

	assign rx   = vert_s1 ? cur_minor_q : cur_major_q;
	assign ry   = vert_s1 ? cur_major_q : cur_minor_q;
	assign rx_e = SUM_W'(rx);
	assign ry_e = SUM_W'(ry);
	assign vx_e = $signed({{(SUM_W-VIEW_BITS){1'b0}}, view_x_q});
	assign vy_e = $signed({{(SUM_W-VIEW_BITS){1'b0}}, view_y_q});
	assign vw_e = $signed({{(SUM_W-VIEW_BITS){1'b0}}, view_w_q});
	assign vh_e = $signed({{(SUM_W-VIEW_BITS){1'b0}}, view_h_q});
	assign sx   = rx_e + vx_e;
	assign sy   = ry_e + vy_e;
	// inside the viewport iff 0 <= rel < size on both axes
	assign vis  = !rx[CB-1] && (rx_e < vw_e) && !ry[CB-1] && (ry_e < vh_e);

	// output register
	logic                    out_valid_q;
	logic signed [PIX_W-1:0] pix_x_q, pix_y_q;
	logic                    vis_q, too_long_out_q, last_q;
	logic [COLOR_W-1:0]      pr_q, pg_q, pb_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit_pix || cmd.emit_reject) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_pix) begin
			pix_x_q        <= sx[PIX_W-1:0];
			pix_y_q        <= sy[PIX_W-1:0];
			vis_q          <= vis;
			pr_q           <= red_q;
			pg_q           <= green_q;
			pb_q           <= blue_q;
			too_long_out_q <= 1'b0;
			last_q         <= points_left_q == CNT_W'(1);
		end else if (cmd.emit_reject) begin
			pix_x_q        <= '0;
			pix_y_q        <= '0;
			vis_q          <= 1'b0;
			pr_q           <= '0;
			pg_q           <= '0;
			pb_q           <= '0;
			too_long_out_q <= 1'b1;
			last_q         <= 1'b1;
		end
	end

	assign out_valid = out_valid_q;
	assign pix_x     = pix_x_q;
	assign pix_y     = pix_y_q;
	assign visible   = vis_q;
	assign pix_red   = pr_q;
	assign pix_green = pg_q;
	assign pix_blue  = pb_q;
	assign too_long  = too_long_out_q;
	assign last      = last_q;

	assign stat.too_long   = too_long_q;
	assign stat.last_point = points_left_q == CNT_W'(1);
	assign stat.out_free   = !out_valid_q || !out_stall;

endmodule

[tb/clr_line_checker.sv]
`timescale 1ns / 1ps
// Line checker for clipped_line_rasterizer: watches cfg, in and out, traces each
// accepted line into a queue of expected pixels and compares every out beat.
// Depends on clr_pkg.
module clr_line_checker import clr_pkg::*; #(
	parameter int COORD_BITS = 12,
	parameter int MAX_SPAN   = 63
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [CFG_ADDR_W-1:0]        cfg_addr,
	input  logic [VIEW_BITS-1:0]         cfg_wdata,
	input  logic                         in_valid,
	input  logic                         in_stall,
	input  logic signed [COORD_BITS-1:0] start_x,
	input  logic signed [COORD_BITS-1:0] start_y,
	input  logic signed [COORD_BITS-1:0] end_x,
	input  logic signed [COORD_BITS-1:0] end_y,
	input  logic [COLOR_W-1:0]           red,
	input  logic [COLOR_W-1:0]           green,
	input  logic [COLOR_W-1:0]           blue,
	input  logic                         out_valid,
	input  logic                         out_stall,
	input  logic signed [PIX_W-1:0]      pix_x,
	input  logic signed [PIX_W-1:0]      pix_y,
	input  logic                         visible,
	input  logic [COLOR_W-1:0]           pix_red,
	input  logic [COLOR_W-1:0]           pix_green,
	input  logic [COLOR_W-1:0]           pix_blue,
	input  logic                         too_long,
	input  logic                         last,
	output int                           errors,
	output int                           pending
);

	typedef struct packed {
		logic [PIX_W-1:0]   x;
		logic [PIX_W-1:0]   y;
		logic               vis;
		logic [COLOR_W-1:0] r;
		logic [COLOR_W-1:0] g;
		logic [COLOR_W-1:0] b;
		logic               rejected;
		logic               last;
	} pixel_t;

	logic [VIEW_BITS-1:0] view_x = '0;
	logic [VIEW_BITS-1:0] view_y = '0;
	logic [VIEW_BITS-1:0] view_w = VIEW_W_RST;
	logic [VIEW_BITS-1:0] view_h = VIEW_H_RST;

	pixel_t pixel_q[$];
	pixel_t got, want;

	initial begin
		errors  = 0;
		pending = 0;
	end

	function automatic int mag(int v);
		return (v < 0) ? -v : v;
	endfunction

	// Bresenham walk from the lower major coordinate, one expected pixel per point
	function automatic void trace_line(int ax, int ay, int bx, int by,
			logic [COLOR_W-1:0] r, logic [COLOR_W-1:0] g, logic [COLOR_W-1:0] b);
		int maj0, maj1, min0, min1, tmp, span, mdelta, mstep, err;
		int maj, mnr, rx, ry, sx, sy, vx, vy, vw, vh;
		bit steep;
		pixel_t p;
		vx = int'(view_x);
		vy = int'(view_y);
		vw = int'(view_w);
		vh = int'(view_h);
		steep = mag(bx - ax) < mag(by - ay);
		if (steep) begin
			maj0 = ay; maj1 = by; min0 = ax; min1 = bx;
		end else begin
			maj0 = ax; maj1 = bx; min0 = ay; min1 = by;
		end
		if (maj0 > maj1) begin
			tmp = maj0; maj0 = maj1; maj1 = tmp;
			tmp = min0; min0 = min1; min1 = tmp;
		end
		span = maj1 - maj0;
		if (span > MAX_SPAN) begin
			p = '0;
			p.rejected = 1'b1;
			p.last     = 1'b1;
			pixel_q.push_back(p);
			return;
		end
		mstep  = (min1 > min0) ? 1 : -1;
		mdelta = mag(min1 - min0);
		err    = 2 * mdelta - span;
		maj    = maj0;
		mnr    = min0;
		for (int k = 0; k <= span; k++) begin
			rx = steep ? mnr : maj;
			ry = steep ? maj : mnr;
			sx = rx + vx;
			sy = ry + vy;
			// clip test on the unwrapped screen position
			p.vis      = sx >= vx && sx < vx + vw && sy >= vy && sy < vy + vh;
			p.x        = sx[PIX_W-1:0];
			p.y        = sy[PIX_W-1:0];
			p.r        = r;
			p.g        = g;
			p.b        = b;
			p.rejected = 1'b0;
			p.last     = (k == span);
			pixel_q.push_back(p);
			maj++;
			if (err >= 0) begin
				mnr += mstep;
				err += 2 * (mdelta - span);
			end else begin
				err += 2 * mdelta;
			end
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			view_x = '0;
			view_y = '0;
			view_w = VIEW_W_RST;
			view_h = VIEW_H_RST;
			pixel_q.delete();
		end else begin
			if (out_valid && !out_stall) begin
				got = '{x: pix_x, y: pix_y, vis: visible, r: pix_red, g: pix_green,
					b: pix_blue, rejected: too_long, last: last};
				if (pixel_q.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("%0t: out beat with nothing expected: x=%0d y=%0d",
							$time, $signed(got.x), $signed(got.y));
				end else begin
					want = pixel_q.pop_front();
					if (got !== want) begin
						errors++;
						if (errors <= 10)
							$display("%0t: pixel mismatch exp x=%0d y=%0d vis=%0b ",
								$time, $signed(want.x), $signed(want.y), want.vis,
								"rgb=%h%h%h too_long=%0b last=%0b, ",
								want.r, want.g, want.b, want.rejected, want.last,
								"got x=%0d y=%0d vis=%0b ",
								$signed(got.x), $signed(got.y), got.vis,
								"rgb=%h%h%h too_long=%0b last=%0b",
								got.r, got.g, got.b, got.rejected, got.last);
					end
				end
			end
			if (in_valid && !in_stall)
				trace_line(int'(start_x), int'(start_y), int'(end_x), int'(end_y),
					red, green, blue);
			if (cfg_we) begin
				case (cfg_addr)
					REG_VIEW_X: view_x = cfg_wdata;
					REG_VIEW_Y: view_y = cfg_wdata;
					REG_VIEW_W: view_w = cfg_wdata;
					REG_VIEW_H: view_h = cfg_wdata;
					default: ;
				endcase
			end
		end
		pending = pixel_q.size();
	end

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
// Top of the clipped_line_rasterizer testbench: clock, reset, viewport writes,
// directed and random line commands, out stalls and the verdict.
// Depends on clr_pkg, clipped_line_rasterizer and clr_line_checker.
module tb;
	import clr_pkg::*;

	localparam int COORD_BITS   = 12;
	localparam int MAX_SPAN     = 63;
	localparam int CYCLE_LIMIT  = 1_000_000;
	localparam int PHASE_LINES  = 25;
	localparam int PHASES       = 5;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	logic                         cfg_we    = 1'b0;
	logic [CFG_ADDR_W-1:0]        cfg_addr  = REG_VIEW_X;
	logic [VIEW_BITS-1:0]         cfg_wdata = '0;
	logic                         in_valid  = 1'b0;
	logic                         in_stall;
	logic signed [COORD_BITS-1:0] start_x   = '0;
	logic signed [COORD_BITS-1:0] start_y   = '0;
	logic signed [COORD_BITS-1:0] end_x     = '0;
	logic signed [COORD_BITS-1:0] end_y     = '0;
	logic [COLOR_W-1:0]           red       = '0;
	logic [COLOR_W-1:0]           green     = '0;
	logic [COLOR_W-1:0]           blue      = '0;
	logic                         out_valid;
	logic                         out_stall = 1'b0;
	logic signed [PIX_W-1:0]      pix_x;
	logic signed [PIX_W-1:0]      pix_y;
	logic                         visible;
	logic [COLOR_W-1:0]           pix_red;
	logic [COLOR_W-1:0]           pix_green;
	logic [COLOR_W-1:0]           pix_blue;
	logic                         too_long;
	logic                         last;

	int errors;
	int pending;
	int cycles    = 0;
	int gap_pct   = 0;
	int stall_pct = 0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	clipped_line_rasterizer #(
		.COORD_BITS(COORD_BITS),
		.MAX_SPAN  (MAX_SPAN)
	) uut (.*);

	clr_line_checker #(
		.COORD_BITS(COORD_BITS),
		.MAX_SPAN  (MAX_SPAN)
	) checker_i (.*);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("clipped_line_rasterizer regression: fail");
			$finish;
		end
	end

	// out side: random stall bursts
	initial begin
		forever begin
			@(negedge clk);
			if (stall_pct > 0 && $urandom_range(99) < stall_pct) begin
				out_stall = 1'b1;
				repeat ($urandom_range(1, 11)) @(negedge clk);
				out_stall = 1'b0;
			end
		end
	end

	task automatic drain();
		@(negedge clk);
		in_valid = 1'b0;
		wait (pending == 0);
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [VIEW_BITS-1:0] data);
		@(negedge clk);
		cfg_we    = 1'b1;
		cfg_addr  = idx;
		cfg_wdata = data;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic set_view(int x, int y, int w, int h);
		drain();
		write_reg(REG_VIEW_X, VIEW_BITS'(x));
		write_reg(REG_VIEW_Y, VIEW_BITS'(y));
		write_reg(REG_VIEW_W, VIEW_BITS'(w));
		write_reg(REG_VIEW_H, VIEW_BITS'(h));
	endtask

	// one line command; valid stays high into the next beat unless a gap is drawn
	task automatic send_line(int ax, int ay, int bx, int by,
			int r = $urandom_range(255), int g = $urandom_range(255),
			int b = $urandom_range(255));
		@(negedge clk);
		if (gap_pct > 0 && $urandom_range(99) < gap_pct) begin
			in_valid = 1'b0;
			repeat ($urandom_range(1, 11)) @(negedge clk);
		end
		start_x  = COORD_BITS'(ax);
		start_y  = COORD_BITS'(ay);
		end_x    = COORD_BITS'(bx);
		end_y    = COORD_BITS'(by);
		red      = COLOR_W'(r);
		green    = COLOR_W'(g);
		blue     = COLOR_W'(b);
		in_valid = 1'b1;
		do @(posedge clk); while (in_stall);
	endtask

	function automatic int rand_coord();
		return int'($urandom_range(4095)) - 2048;
	endfunction

	// mostly lines within the span limit, some just over it, a few wild ones
	task automatic random_line();
		int ax, ay, bx, by, dx, dy;
		if ($urandom_range(1)) begin
			ax = int'($urandom_range(400)) - 40;
			ay = int'($urandom_range(300)) - 30;
		end else begin
			ax = rand_coord();
			ay = rand_coord();
		end
		if ($urandom_range(9) == 0) begin
			bx = rand_coord();
			by = rand_coord();
		end else begin
			dx = int'($urandom_range(130)) - 65;
			dy = int'($urandom_range(130)) - 65;
			if ($urandom_range(3) == 0)
				dy = dy / 8;
			bx = ax + dx;
			by = ay + dy;
			if (bx > 2047 || bx < -2048)
				bx = ax - dx;
			if (by > 2047 || by < -2048)
				by = ay - dy;
		end
		send_line(ax, ay, bx, by);
	endtask

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed lines against the reset viewport
		gap_pct   = 20;
		stall_pct = 10;
		send_line(0, 0, 0, 0, 0, 0, 0);
		send_line(-2048, -2048, -2048, -2048, 255, 255, 255);
		send_line(2047, 2047, 2047, 2047, 255, 0, 255);
		send_line(0, 0, 10, 0);
		send_line(10, 5, 0, 5);
		send_line(0, 0, 0, 10);
		send_line(3, 10, 0, 0);
		send_line(0, 0, 5, 5);
		send_line(5, 5, 0, 0);
		send_line(0, 5, 5, 0);
		send_line(0, 0, 63, 20);
		send_line(20, 63, 0, 0);
		send_line(0, 0, 64, 0);
		send_line(0, 0, 0, -64);
		send_line(-2048, -2048, 2047, 2047);
		send_line(2047, -2048, -2048, 2047);
		send_line(-5, -3, 10, 7);
		send_line(315, 235, 325, 245);
		send_line(2037, 2047, 2047, 2040);
		send_line(-2048, -2048, -2000, -2030);
		send_line(-1, 0, 319, 0);
		send_line(0, 239, 0, 200, 0, 255, 0);

		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: set_view(100, 50, 64, 32);
				1: set_view(4095, 4095, 4095, 4095);
				2: set_view(0, 0, 0, 0);
				3: set_view($urandom_range(4095), $urandom_range(4095),
					$urandom_range(400), $urandom_range(400));
				default: set_view(0, 0, 4095, 4095);
			endcase
			if (ph < PHASES - 1) begin
				gap_pct   = 25 * $urandom_range(2);
				stall_pct = 10 * $urandom_range(2);
			end else begin
				gap_pct   = 0;
				stall_pct = 0;
			end
			for (int n = 0; n < PHASE_LINES; n++) begin
				if (ph == 3 && n == PHASE_LINES / 2)
					drain();
				random_line();
			end
		end

		drain();
		repeat (20) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("clipped_line_rasterizer regression: pass");
		else
			$display("clipped_line_rasterizer regression: fail");
		$finish;
	end

endmodule

[sim.f]
rtl/clr_pkg.sv
rtl/clr_ctrl.sv
rtl/clr_datapath.sv
rtl/clipped_line_rasterizer.sv
tb/clr_line_checker.sv
tb/tb.sv
